>>> rtl/rc_pwm_capture_and_scale_macros.svh
// Assertion macros shared by the checker of the pulse capture block.
`ifndef RC_PWM_CAPTURE_AND_SCALE_MACROS_SVH
`define RC_PWM_CAPTURE_AND_SCALE_MACROS_SVH
// Same-cycle implication, clocked on i_clk and quiet during reset.
`define RCPWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcpwm check failed");
// Next-cycle implication, clocked on i_clk and quiet during reset.
`define RCPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcpwm check failed");
`endif

>>> rtl/rcpwm_pkg.sv
// Shared constants, types and lane status for the pulse capture block.
package rcpwm_pkg;
    localparam int CHANNELS  = 5;
    localparam int TIME_BITS = 32;
    localparam int CAL_BITS  = 49;
    localparam int WID_BITS  = 16;
    localparam int OUT_BITS  = 11;
    localparam int IDX_BITS  = 3;
    localparam int Q_BITS    = 10;
    localparam int PROD_BITS = 25;
    localparam int QCNT_BITS = 4;

    localparam logic [CAL_BITS-1:0] CAL_RESET = 49'd6442582017000;
    localparam logic [OUT_BITS-1:0] MID       = 11'd1500;
    localparam logic [8:0]          SPAN      = 9'd500;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PREP,
        L_MUL,
        L_DIV,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic                done;
        logic                updated;
        logic [OUT_BITS-1:0] scaled;
    } t_lane_stat;
endpackage

>>> rtl/rcpwm_lane.sv
// One channel lane: edge capture, width store and calibrated scaling.
module rcpwm_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_pin,
    input  logic [rcpwm_pkg::TIME_BITS-1:0] i_time,
    input  logic [rcpwm_pkg::CAL_BITS-1:0]  i_cal,
    input  logic                            i_ack,
    output rcpwm_pkg::t_lane_stat           o_stat
);
    import rcpwm_pkg::*;

    t_lane_state r_state, n_state;
    logic                  r_level;
    logic [TIME_BITS-1:0]  r_rise;
    logic [WID_BITS-1:0]   r_width;
    logic                  r_upd;
    logic [WID_BITS-1:0]   r_num, r_den;
    logic                  r_low_side, r_mid;
    logic [PROD_BITS-1:0]  r_rem;
    logic [Q_BITS-1:0]     r_q;
    logic [QCNT_BITS-1:0]  r_cnt;

    logic [TIME_BITS-1:0]  w_dt;
    logic [WID_BITS-1:0]   w_lo, w_hi, w_ctr, w_clamp;
    logic [WID_BITS:0]     w_num_s, w_den_s;
    logic [WID_BITS-1:0]   w_num_a, w_den_a;
    logic                  w_below, w_above;
    logic [PROD_BITS:0]    w_dsh;
    logic                  w_add;

    assign w_lo  = i_cal[15:0];
    assign w_hi  = i_cal[31:16];
    assign w_ctr = i_cal[47:32];
    assign w_dt  = i_time - r_rise;

    // Side selection, clamp and magnitudes of numerator and divisor.
    always_comb begin
        w_below = r_width < w_ctr;
        w_above = r_width > w_ctr;
        if (w_below) begin
            w_clamp = (r_width < w_lo) ? w_lo : r_width;
            w_num_s = {1'b0, w_ctr} - {1'b0, w_clamp};
            w_den_s = {1'b0, w_ctr} - {1'b0, w_lo};
        end else begin
            w_clamp = (r_width > w_hi) ? w_hi : r_width;
            w_num_s = {1'b0, w_clamp} - {1'b0, w_ctr};
            w_den_s = {1'b0, w_hi} - {1'b0, w_ctr};
        end
        w_num_a = w_num_s[WID_BITS] ? WID_BITS'(-w_num_s) : w_num_s[WID_BITS-1:0];
        w_den_a = w_den_s[WID_BITS] ? WID_BITS'(-w_den_s) : w_den_s[WID_BITS-1:0];
    end

    // Divisor aligned to the current quotient bit.
    assign w_dsh = (PROD_BITS+1)'({r_den, {(Q_BITS-1){1'b0}}} >> (Q_BITS-1-int'(r_cnt)));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: if (i_start) n_state = L_PREP;
            L_PREP: n_state = L_MUL;
            L_MUL:  n_state = L_DIV;
            L_DIV:  if (r_cnt == '0) n_state = L_DONE;
            L_DONE: if (i_ack) n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    // Edge capture state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_rise  <= '0;
            r_width <= '0;
            r_upd   <= 1'b0;
        end else if (i_start) begin
            r_upd <= 1'b0;
            if (i_pin && !r_level) begin
                r_level <= 1'b1;
                r_rise  <= i_time;
            end else if (!i_pin && r_level) begin
                r_level <= 1'b0;
                r_width <= (w_dt > TIME_BITS'(16'hFFFF)) ? 16'hFFFF : w_dt[WID_BITS-1:0];
                r_upd   <= 1'b1;
            end
        end
    end

    // Scaling datapath: setup, product, then one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_PREP: begin
                r_num      <= w_num_a;
                r_den      <= w_den_a;
                r_low_side <= w_below;
                r_mid      <= !(w_below || w_above) || (w_den_a == '0);
            end
            L_MUL: begin
                r_rem <= PROD_BITS'(r_num) * PROD_BITS'(SPAN);
                r_q   <= '0;
                r_cnt <= QCNT_BITS'(Q_BITS-1);
            end
            L_DIV: begin
                if ({1'b0, r_rem} >= w_dsh) begin
                    r_rem        <= r_rem - w_dsh[PROD_BITS-1:0];
                    r_q[r_cnt]   <= 1'b1;
                end
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
            default: ;
        endcase
    end

    assign w_add = r_low_side ? i_cal[48] : !i_cal[48];

    always_comb begin
        o_stat.done    = (r_state == L_DONE);
        o_stat.updated = r_upd;
        if (r_mid) begin
            o_stat.scaled = MID;
        end else if (w_add) begin
            o_stat.scaled = MID + OUT_BITS'(r_q);
        end else begin
            o_stat.scaled = MID - OUT_BITS'(r_q);
        end
    end
endmodule

>>> rtl/rc_pwm_capture_and_scale.sv
// Top level of the receiver pulse-width capture and scaling block.
// Usage:
// - Input channel (i_in_valid/o_in_ready) takes one item per pin-change
//   event: the five pin levels and a 32-bit microsecond timestamp.
// - Config channel (i_cfg_valid/o_cfg_ready) is always ready; index 0..4
//   selects a channel calibration, other indexes are ignored. Write it idle.
// - Output channel (o_out_valid/i_out_ready) carries five scaled values and
//   the mask of channels that completed a pulse on this event.
// Timing:
// - Five lanes run side by side; each steps through setup, a multiply and
//   a bit-serial divide that yields ten quotient bits, then holds the
//   result until the merge stage registers it.
// - One item at a time: a new item is taken only once the lanes'
//   bit-serial dividers finish and the result enters the output register.
// - A stalled receiver holds the result in the output register; the lanes
//   may take and finish the next item, then wait for that register.
// Reset clears edge state, widths and valid flags, and loads the default
// calibration (1000/2000/1500, not reversed).
module rc_pwm_capture_and_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rcpwm_pkg::CHANNELS-1:0]      i_pin_levels,
    input  logic [rcpwm_pkg::TIME_BITS-1:0]     i_time_us,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rcpwm_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  logic [rcpwm_pkg::CAL_BITS-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rcpwm_pkg::OUT_BITS-1:0]      o_scaled_ch1,
    output logic [rcpwm_pkg::OUT_BITS-1:0]      o_scaled_ch2,
    output logic [rcpwm_pkg::OUT_BITS-1:0]      o_scaled_ch3,
    output logic [rcpwm_pkg::OUT_BITS-1:0]      o_scaled_ch4,
    output logic [rcpwm_pkg::OUT_BITS-1:0]      o_scaled_ch5,
    output logic [rcpwm_pkg::CHANNELS-1:0]      o_updated_mask
);
    import rcpwm_pkg::*;

    logic [CAL_BITS-1:0] r_cal [CHANNELS];
    logic                r_busy;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_scaled [CHANNELS];
    logic [CHANNELS-1:0] r_mask;
    t_lane_stat          w_stat [CHANNELS];
    logic [CHANNELS-1:0] w_done;
    logic                w_start, w_load;

    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign w_start     = i_in_valid && !r_busy;
    assign w_load      = r_busy && (&w_done) && (!r_out_valid || i_out_ready);

    // Calibration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) r_cal[i] <= CAL_RESET;
        end else if (i_cfg_valid && (int'(i_cfg_index) < CHANNELS)) begin
            r_cal[i_cfg_index] <= i_cfg_data;
        end
    end

    // Channel lanes.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        rcpwm_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_pin   (i_pin_levels[g]),
            .i_time  (i_time_us),
            .i_cal   (r_cal[g]),
            .i_ack   (w_load),
            .o_stat  (w_stat[g])
        );
        assign w_done[g] = w_stat[g].done;
    end

    // Merge stage: busy flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) r_busy <= 1'b1;
            else if (w_load) r_busy <= 1'b0;
            if (w_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_scaled[i] <= w_stat[i].scaled;
                r_mask[i]   <= w_stat[i].updated;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scaled_ch1   = r_scaled[0];
    assign o_scaled_ch2   = r_scaled[1];
    assign o_scaled_ch3   = r_scaled[2];
    assign o_scaled_ch4   = r_scaled[3];
    assign o_scaled_ch5   = r_scaled[4];
    assign o_updated_mask = r_mask;
endmodule

>>> rtl/rcpwm_checker.sv
// Port-level checker for the pulse capture block and its bind.
`include "rc_pwm_capture_and_scale_macros.svh"
module rcpwm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [rcpwm_pkg::OUT_BITS-1:0]   o_scaled_ch1,
    input logic [rcpwm_pkg::OUT_BITS-1:0]   o_scaled_ch5,
    input logic [rcpwm_pkg::CHANNELS-1:0]   o_updated_mask
);
    import rcpwm_pkg::*;

    // A stalled result stays offered with the same mask.
    `RCPWM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_updated_mask))
    // Offered scaled values on channels 1 and 5 lie in 1000..2000.
    `RCPWM_ASSERT_NOW(a_range, o_out_valid, o_scaled_ch1 >= 11'd1000 && o_scaled_ch1 <= 11'd2000 && o_scaled_ch5 >= 11'd1000 && o_scaled_ch5 <= 11'd2000)
    // One item at a time: the block is busy right after an accept.
    `RCPWM_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready)
endmodule

bind rc_pwm_capture_and_scale rcpwm_checker u_rcpwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_scaled_ch1   (o_scaled_ch1),
    .o_scaled_ch5   (o_scaled_ch5),
    .o_updated_mask (o_updated_mask)
);
